>>> rtl/vpe_pkg.sv
// package for the varint phrase entry parser
// holds result kinds, framing phases, the queue token and shared sizes
// no dependencies
package vpe_pkg;

  // payload bits per encoded byte and the continuation flag position
  localparam int GROUP_BITS = 7;
  localparam int CONT_BIT = 7;

  // default decoded value width and fixed result width
  localparam int DEF_VALUE_BITS = 32;
  localparam int OUT_BITS = 32;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // score count after reset
  localparam logic [7:0] SCORE_COUNT_RST = 8'd4;

  typedef enum logic [2:0] {
    K_WORD      = 3'd0,
    K_WORD_END  = 3'd1,
    K_SCORE     = 3'd2,
    K_SCORE_END = 3'd3,
    K_ALIGN     = 3'd4,
    K_ENTRY_END = 3'd5,
    K_BAD_SEP   = 3'd6,
    K_TRUNC     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_WORD  = 2'd0,
    PH_SCORE = 2'd1,
    PH_DELIM = 2'd2,
    PH_ALIGN = 2'd3
  } phase_t;

  // one finished (or cut off) value handed from front to back
  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                zero;
    logic                more;
    logic                last;
    logic                ovf;
  } token_t;

  // queue status seen by the top level
  typedef struct packed {
    logic                               full;
    logic                               empty;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   count;
  } queue_stat_t;

endpackage

>>> rtl/vpe_if.sv
// valid/ready channel interfaces for the byte input and the result output
// depends on vpe_pkg
interface vpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       line_end;

  modport source (output valid, output code_byte, output line_end, input ready);
  modport sink (input valid, input code_byte, input line_end, output ready);
endinterface

interface vpe_result_if;
  import vpe_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] value;
  kind_t               kind;
  logic                overflow;

  modport source (output valid, output value, output kind, output overflow, input ready);
  modport sink (input valid, input value, input kind, input overflow, output ready);
endinterface

>>> rtl/varint_phrase_entry_parser.sv
// top level of the varint phrase entry parser
// depends on vpe_pkg, vpe_if, vpe_front, vpe_queue and vpe_back
//
// Usage:
//   bytes   : one encoded byte per transaction (code_byte, line_end), bit 7
//             of code_byte marks that more bytes of the value follow.
//   results : one transaction per finished value or line end, carrying the
//             value, its kind and an overflow flag; mid-value bytes give none.
//   cfg_we/cfg_wdata : writes score_count; write only while the block is idle.
// Path: the byte ending a value writes a token into the queue at the edge
//   that takes it; the back end moves the token into the result register
//   once it is at the queue head and the result register is free or being taken.
// Throughput: one byte per cycle while the queue is not full, set by the
//   combinational shift-or in the front end and the phase update in the back end.
// Reset: rst clears the value being gathered, the entry framing, the queue
//   and the result valid flag, and sets score_count to 4.
// Stall: while results is held, tokens collect in a two-entry queue; once it
//   is full, bytes.ready drops until a result is taken.
module varint_phrase_entry_parser #(
  parameter int VALUE_BITS = vpe_pkg::DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  vpe_byte_if.sink     bytes,
  vpe_result_if.source results,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata
);
  import vpe_pkg::*;

  token_t      push_data;
  token_t      pop_data;
  queue_stat_t q_stat;
  logic        push;
  logic        pop;

  // byte gathering
  vpe_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_ready  (bytes.ready),
    .code_byte (bytes.code_byte),
    .line_end  (bytes.line_end),
    .q_full    (q_stat.full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  vpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // entry framing and result output
  vpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .tok_valid    (!q_stat.empty),
    .tok          (pop_data),
    .pop          (pop),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_value    (results.value),
    .res_kind     (results.kind),
    .res_overflow (results.overflow)
  );

`ifndef SYNTH
  // a line end always leaves a token behind
  a_line_end_token: assert property (@(posedge clk) disable iff (rst)
    bytes.valid && bytes.ready && bytes.line_end |=> !q_stat.empty)
    else $error("line end byte produced no token");

  // delimiter kinds carry a zero value
  a_delim_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.kind == K_WORD_END || results.kind == K_SCORE_END ||
    results.kind == K_ENTRY_END) |-> results.value == '0)
    else $error("delimiter result with nonzero value");

  // queue fill count stays within its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("token queue overfilled");
`endif

endmodule

>>> rtl/vpe_front.sv
// front end: gathers encoded bytes into values and emits one token per value end or line end
// depends on vpe_pkg
module vpe_front #(
  parameter int VALUE_BITS = vpe_pkg::DEF_VALUE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      code_byte,
  input  logic            line_end,
  input  logic            q_full,
  output logic            push,
  output vpe_pkg::token_t push_data
);
  import vpe_pkg::*;

  localparam int MAX_BYTES = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int POS_W = $clog2(MAX_BYTES + 2);
  localparam int WIDE_BITS = VALUE_BITS + GROUP_BITS;
  localparam int SH_W = $clog2(WIDE_BITS);

  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_next;
  logic [SH_W-1:0]       sh;
  logic [WIDE_BITS-1:0]  shifted;
  logic [VALUE_BITS-1:0] acc_add;
  logic [POS_W-1:0]      pos_add;
  logic                  more;
  logic                  ovf;
  logic                  take;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;
  assign more = code_byte[CONT_BIT];

  // place the payload group at its byte position
  always_comb begin
    sh = SH_W'(pos) * SH_W'(GROUP_BITS);
    shifted = WIDE_BITS'(code_byte[GROUP_BITS-1:0]) << sh;
    if (pos < POS_W'(MAX_BYTES)) begin
      acc_add = acc | shifted[VALUE_BITS-1:0];
      pos_add = pos + POS_W'(1);
    end else begin
      acc_add = acc;
      pos_add = POS_W'(MAX_BYTES + 1);
    end
    ovf = pos_add > POS_W'(MAX_BYTES);
  end

  // token on a value end or a line end, otherwise keep gathering
  always_comb begin
    push = take && (!more || line_end);
    push_data.value = OUT_BITS'(acc_add);
    push_data.zero = (acc_add == '0);
    push_data.more = more;
    push_data.last = line_end;
    push_data.ovf = ovf;
    acc_next = acc;
    pos_next = pos;
    if (take) begin
      if (more && !line_end) begin
        acc_next = acc_add;
        pos_next = pos_add;
      end else begin
        acc_next = '0;
        pos_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pos <= '0;
    end else begin
      acc <= acc_next;
      pos <= pos_next;
    end
  end

endmodule

>>> rtl/vpe_queue.sv
// short token queue that decouples the front end from the framing back end
// depends on vpe_pkg
module vpe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vpe_pkg::token_t     push_data,
  input  logic                pop,
  output vpe_pkg::token_t     pop_data,
  output vpe_pkg::queue_stat_t stat
);
  import vpe_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign stat.count = count;
  assign stat.full = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  // token storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/vpe_back.sv
// back end: entry framing machine, score count register and result register
// depends on vpe_pkg
module vpe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            tok_valid,
  input  vpe_pkg::token_t tok,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [vpe_pkg::OUT_BITS-1:0] res_value,
  output vpe_pkg::kind_t  res_kind,
  output logic            res_overflow
);
  import vpe_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic [7:0]           scores_left;
  logic [7:0]           scores_left_next;
  logic [7:0]           score_count;
  logic [7:0]           dec_left;
  kind_t                kind;
  logic [OUT_BITS-1:0]  value;

  assign pop = tok_valid && (!res_valid || res_ready);

  // framing: class the token and advance the phase
  always_comb begin
    phase_next = phase;
    scores_left_next = scores_left;
    dec_left = (scores_left != 8'd0) ? scores_left - 8'd1 : scores_left;
    kind = K_TRUNC;
    if (!tok.more) begin
      case (phase)
        PH_WORD: begin
          if (!tok.zero) begin
            kind = K_WORD;
          end else begin
            kind = K_WORD_END;
            scores_left_next = score_count;
            phase_next = (score_count == 8'd0) ? PH_DELIM : PH_SCORE;
          end
        end
        PH_SCORE: begin
          kind = K_SCORE;
          scores_left_next = dec_left;
          if (dec_left == 8'd0) begin
            phase_next = PH_DELIM;
          end
        end
        PH_DELIM: begin
          if (tok.zero) begin
            kind = K_SCORE_END;
            phase_next = PH_ALIGN;
          end else begin
            kind = K_BAD_SEP;
            scores_left_next = score_count;
            phase_next = (score_count == 8'd0) ? PH_DELIM : PH_SCORE;
          end
        end
        PH_ALIGN: begin
          if (!tok.zero) begin
            kind = K_ALIGN;
          end else begin
            kind = K_ENTRY_END;
            phase_next = PH_WORD;
          end
        end
        default: begin
          kind = K_TRUNC;
        end
      endcase
    end
    // line end closes the entry or reports it cut off
    if (tok.last) begin
      if (kind != K_ENTRY_END) begin
        kind = K_TRUNC;
      end
      phase_next = PH_WORD;
      scores_left_next = 8'd0;
    end
    if (kind == K_WORD_END || kind == K_SCORE_END || kind == K_ENTRY_END) begin
      value = '0;
    end else begin
      value = tok.value;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WORD;
      scores_left <= 8'd0;
    end else if (pop) begin
      phase <= phase_next;
      scores_left <= scores_left_next;
    end
  end

  // score count register
  always_ff @(posedge clk) begin
    if (rst) begin
      score_count <= SCORE_COUNT_RST;
    end else if (cfg_we) begin
      score_count <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_value <= value;
      res_kind <= kind;
      res_overflow <= tok.ovf;
    end
  end

endmodule

>>> tb/tb.sv
// self-checking testbench for varint_phrase_entry_parser
// drives encoded phrase-table lines and checks every result against a built-in decoder
// depends on vpe_pkg, vpe_if and the varint_phrase_entry_parser rtl
module tb;
  import vpe_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RST_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 380;
  localparam int MAX_GROUPS = 5;
  localparam int RUN_LIMIT = CLK_PERIOD * 600000;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    kind_t               kind;
    logic                ovf;
  } result_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  vpe_byte_if   byte_ch ();
  vpe_result_if res_ch ();

  varint_phrase_entry_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .bytes     (byte_ch),
    .results   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state mirrored by the testbench
  logic [31:0] acc_q;
  logic [2:0]  group_pos;
  phase_t      framing;
  logic [7:0]  scores_due;
  logic [7:0]  score_cfg;

  result_t     expected_results[$];
  logic [7:0]  line_bytes[$];
  int          errors;
  int          bytes_sent;
  bit          src_idle_on;
  bit          snk_idle_on;
  int          hold_len;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("varint_phrase_entry_parser: mismatch");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic void begin_scores();
    scores_due = score_cfg;
    framing = (score_cfg == 8'd0) ? PH_DELIM : PH_SCORE;
  endfunction

  // decodes one byte and returns the result it causes, if any
  function automatic void decode_byte(input logic [7:0] b, input logic last,
                                      output logic emit, output result_t r);
    logic        more;
    logic        ovf;
    logic        zero;
    logic [31:0] grp;
    logic [31:0] v;
    kind_t       k;
    more = b[7];
    ovf = 1'b0;
    emit = 1'b0;
    r = '0;
    // gather payload bits, saturate the position past the last group
    if (group_pos < MAX_GROUPS) begin
      grp = {25'd0, b[6:0]};
      acc_q = acc_q | (grp << (7 * group_pos));
      group_pos = group_pos + 3'd1;
    end else begin
      group_pos = 3'(MAX_GROUPS + 1);
    end
    if (group_pos > MAX_GROUPS) ovf = 1'b1;
    v = acc_q;
    if (more && !last) return;
    if (!more) begin
      acc_q = '0;
      group_pos = '0;
      zero = (v == 32'd0);
      // entry framing
      case (framing)
        PH_WORD: begin
          if (!zero) k = K_WORD;
          else begin
            begin_scores();
            k = K_WORD_END;
          end
        end
        PH_SCORE: begin
          if (scores_due > 0) scores_due = scores_due - 8'd1;
          if (scores_due == 0) framing = PH_DELIM;
          k = K_SCORE;
        end
        PH_DELIM: begin
          if (zero) begin
            framing = PH_ALIGN;
            k = K_SCORE_END;
          end else begin
            begin_scores();
            k = K_BAD_SEP;
          end
        end
        default: begin
          if (!zero) k = K_ALIGN;
          else begin
            framing = PH_WORD;
            k = K_ENTRY_END;
          end
        end
      endcase
    end else begin
      k = K_TRUNC;
    end
    // line end clears everything but the score count
    if (last) begin
      if (k != K_ENTRY_END) k = K_TRUNC;
      acc_q = '0;
      group_pos = '0;
      framing = PH_WORD;
      scores_due = '0;
    end
    if (k == K_WORD_END || k == K_SCORE_END || k == K_ENTRY_END) v = '0;
    emit = 1'b1;
    r.value = v;
    r.kind = k;
    r.ovf = ovf;
  endfunction

  // one byte transaction, prediction at acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    emit;
    int      g;
    byte_ch.valid <= 1'b1;
    byte_ch.code_byte <= b;
    byte_ch.line_end <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b, last, emit, r);
    if (emit) expected_results.insert(expected_results.size(), r);
    bytes_sent++;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      g = gap_len();
      byte_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait until every expected result has come, then let the pipe settle
  task automatic wait_drain();
    byte_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_score_count(input logic [7:0] n);
    wait_drain();
    cfg_wdata <= n;
    cfg_we <= 1'b1;
    @(posedge clk);
    score_cfg = n;
    cfg_we <= 1'b0;
  endtask

  // queue one value as ulEB128 bytes, pad adds redundant zero groups
  function automatic void add_value(input logic [31:0] v, input int pad);
    int          n;
    int          total;
    logic [31:0] t;
    logic [31:0] sh;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    total = n + pad;
    for (int i = 0; i < total; i++) begin
      sh = (i < MAX_GROUPS) ? (v >> (7 * i)) : 32'd0;
      line_bytes.insert(line_bytes.size(), {(i < total - 1) ? 1'b1 : 1'b0, sh[6:0]});
    end
  endfunction

  function automatic logic [31:0] rand_val();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: v = v & 32'h7f;
      1: v = v & 32'h3fff;
      2: v = v >> $urandom_range(0, 31);
      3: v = v & 32'h1fffff;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] nz_val();
    logic [31:0] v;
    v = rand_val();
    if (v == 32'd0) v = 32'd1;
    return v;
  endfunction

  function automatic int rand_pad();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // well-formed entry with random content, sometimes with a bad separator
  function automatic void add_entry(input int nw, input int na);
    int runs;
    runs = ($urandom_range(0, 7) == 0) ? 2 : 1;
    for (int i = 0; i < nw; i++) add_value(nz_val(), rand_pad());
    add_value(32'd0, rand_pad());
    for (int j = 0; j < runs; j++) begin
      if (j > 0) add_value(nz_val(), rand_pad());
      for (int i = 0; i < score_cfg; i++)
        add_value(($urandom_range(0, 3) == 0) ? 32'd0 : rand_val(), rand_pad());
    end
    add_value(32'd0, rand_pad());
    for (int i = 0; i < na; i++) add_value(nz_val(), rand_pad());
    add_value(32'd0, rand_pad());
  endfunction

  // send queued bytes; cut >= 0 ends the line early at that byte
  task automatic send_line(input bit end_line, input int cut);
    int n;
    n = line_bytes.size();
    if (cut >= 0 && cut < n) n = cut + 1;
    for (int i = 0; i < n; i++)
      send_byte(line_bytes[i], end_line && (i == n - 1));
    line_bytes.delete();
  endtask

  // ---------------------------------------------------------------- tests

  // reset score count of four, extremes of value size
  task automatic test_default_entry();
    add_value(32'h7f, 0);
    add_value(32'hffffffff, 0);
    add_value(32'd0, 0);
    add_value(32'd0, 0);
    add_value(32'h80, 0);
    add_value(32'h3fff, 0);
    add_value(32'h3f800000, 0);
    add_value(32'd0, 0);
    add_value(32'd1, 0);
    add_value(32'd0, 0);
    send_line(1'b1, -1);
  endtask

  // dropped high bits, overlong values, line end mid value
  task automatic test_overflow_and_truncation();
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    add_value(32'h15, 3);
    send_line(1'b0, -1);
    send_byte(8'h85, 1'b1);
    send_byte(8'h09, 1'b1);
    send_byte(8'h00, 1'b1);
    add_value(32'd2, 6);
    send_line(1'b1, 6);
  endtask

  // bad separator and zero score count
  task automatic test_framing_cases();
    set_score_count(8'd1);
    add_value(32'd3, 0);
    add_value(32'd0, 0);
    add_value(32'd9, 0);
    add_value(32'd7, 0);
    add_value(32'd0, 0);
    add_value(32'd0, 0);
    add_value(32'd0, 0);
    send_line(1'b1, -1);
    set_score_count(8'd0);
    add_value(32'd5, 0);
    add_value(32'd0, 0);
    add_value(32'd0, 0);
    add_value(32'd6, 0);
    add_value(32'd0, 0);
    send_line(1'b1, -1);
  endtask

  // largest score count, short one-byte scores
  task automatic test_max_score_count();
    set_score_count(8'd255);
    add_value(32'd11, 0);
    add_value(32'd0, 0);
    for (int i = 0; i < 255; i++) add_value(32'(i & 63), 0);
    add_value(32'd0, 0);
    add_value(32'd12, 0);
    add_value(32'd0, 0);
    send_line(1'b1, -1);
    set_score_count(8'd4);
  endtask

  // result side held off while bytes keep coming
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    hold_len = 60;
    add_entry(4, 4);
    add_entry(3, 2);
    send_line(1'b1, -1);
    wait_drain();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_lines();
    int stop_at;
    int sel;
    int n;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_entry($urandom_range(1, 4), $urandom_range(0, 4));
        send_line(1'b1, -1);
      end else if (sel < 70) begin
        add_entry($urandom_range(1, 3), $urandom_range(0, 3));
        send_line(1'b0, -1);
      end else if (sel < 82) begin
        // broken line, cut at a random byte
        add_entry($urandom_range(1, 3), $urandom_range(0, 3));
        send_line(1'b1, $urandom_range(0, line_bytes.size() - 1));
      end else if (sel < 92) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end else if (sel < 96) begin
        set_score_count(8'($urandom_range(0, 6)));
      end else begin
        src_idle_on = $urandom_range(0, 2) != 0;
        snk_idle_on = $urandom_range(0, 2) != 0;
      end
    end
  endtask

  // result pacing, with an occasional long hold-off
  initial begin : sink_pacing
    int n;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h kind=%0d overflow=%b", $time,
                 res_ch.value, res_ch.kind, res_ch.overflow);
      end else begin
        e = expected_results.pop_front();
        if (res_ch.value !== e.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, e.value, res_ch.value);
        end
        if (res_ch.kind !== e.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, res_ch.kind);
        end
        if (res_ch.overflow !== e.ovf) begin
          errors++;
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, res_ch.overflow);
        end
      end
    end
  end

  // reset, tests in turn, final verdict
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'd0;
    byte_ch.valid <= 1'b0;
    byte_ch.code_byte <= 8'd0;
    byte_ch.line_end <= 1'b0;
    acc_q = '0;
    group_pos = '0;
    framing = PH_WORD;
    scores_due = '0;
    score_cfg = SCORE_COUNT_RST;
    errors = 0;
    bytes_sent = 0;
    hold_len = 0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_entry();
    test_overflow_and_truncation();
    test_framing_cases();
    test_max_score_count();
    test_backpressure();
    test_random_lines();

    wait_drain();
    if (errors == 0 && expected_results.size() == 0)
      $display("varint_phrase_entry_parser: match");
    else
      $display("varint_phrase_entry_parser: mismatch");
    $finish;
  end

endmodule
